// ----- sv/octbl_pkg.sv -----
// ----------------------------------------------------------------------------
// octbl_pkg
// Shared types, register codes, reset values and the digit split helper of
// the octet blink-code sequencer.
// ----------------------------------------------------------------------------
package octbl_pkg;

    // field widths
    localparam int RGB_W   = 24;
    localparam int TIME_W  = 16;
    localparam int OCTET_W = 8;
    localparam int KIND_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int CFG_IDX_W = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOLID = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ON    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP = 3'd5;

    // register reset values
    localparam logic [RGB_W-1:0]  RST_ON_COLOR   = 24'd10240;
    localparam logic [TIME_W-1:0] RST_PULSE_ON   = 16'd180;
    localparam logic [TIME_W-1:0] RST_PULSE_OFF  = 16'd220;
    localparam logic [TIME_W-1:0] RST_ZERO_ON    = 16'd600;
    localparam logic [TIME_W-1:0] RST_DIGIT_GAP  = 16'd700;
    localparam logic [TIME_W-1:0] RST_REPEAT_GAP = 16'd2200;

    // sequencer phases
    typedef enum logic [1:0] {
        PHASE_ON   = 2'd0,
        PHASE_OFF  = 2'd1,
        PHASE_DGAP = 2'd2,
        PHASE_RGAP = 2'd3
    } phase_t;

    // configuration register set
    typedef struct packed {
        logic [RGB_W-1:0]  on_color;
        logic [TIME_W-1:0] pulse_on_time;
        logic [TIME_W-1:0] pulse_off_time;
        logic [TIME_W-1:0] zero_on_time;
        logic [TIME_W-1:0] digit_gap_time;
        logic [TIME_W-1:0] repeat_gap_time;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OCTET_W-1:0] octet_value;
        logic [RGB_W-1:0]   solid_color;
    } item_t;

    // result of one step of the sequencer
    typedef struct packed {
        logic             valid;
        logic [RGB_W-1:0] rgb;
    } result_t;

    // decimal digits of a byte, leading zeros dropped
    typedef struct packed {
        logic [DIGIT_W-1:0] d0;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d2;
        logic [1:0]         count;
    } split_t;

    // Hundreds by compare, tens by the 205/2048 reciprocal (exact below 100)
    function automatic split_t split_octet(input logic [OCTET_W-1:0] v);
        split_t      s;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  u;
        if (v >= 8'd200)
            h = 2'd2;
        else if (v >= 8'd100)
            h = 2'd1;
        else
            h = 2'd0;
        r    = 7'(v - 8'({6'b000000, h} * 8'd100));
        prod = 15'({8'b00000000, r} * 15'd205);
        t    = prod[14:11];
        u    = 4'(r - 7'({3'b000, t} * 7'd10));
        if (v >= 8'd100) begin
            s.d0 = {2'b00, h};
            s.d1 = t;
            s.d2 = u;
            s.count = 2'd3;
        end else if (v >= 8'd10) begin
            s.d0 = t;
            s.d1 = u;
            s.d2 = u;
            s.count = 2'd2;
        end else begin
            s.d0 = u;
            s.d1 = u;
            s.d2 = u;
            s.count = 2'd1;
        end
        return s;
    endfunction

endpackage

// ----- sv/octbl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// octbl_cfg_regs
// Configuration register file: colour and phase times, write only.
// ----------------------------------------------------------------------------
module octbl_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [octbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [octbl_pkg::RGB_W-1:0]         cfg_wdata,
    output octbl_pkg::cfg_t                     cfg
);

    octbl_pkg::cfg_t cfg_reg;
    octbl_pkg::cfg_t cfg_next;

    // decode a write; unknown indexes fall through
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                octbl_pkg::CFG_ON_COLOR:   cfg_next.on_color = cfg_wdata;
                octbl_pkg::CFG_PULSE_ON:
                    cfg_next.pulse_on_time = cfg_wdata[octbl_pkg::TIME_W-1:0];
                octbl_pkg::CFG_PULSE_OFF:
                    cfg_next.pulse_off_time = cfg_wdata[octbl_pkg::TIME_W-1:0];
                octbl_pkg::CFG_ZERO_ON:
                    cfg_next.zero_on_time = cfg_wdata[octbl_pkg::TIME_W-1:0];
                octbl_pkg::CFG_DIGIT_GAP:
                    cfg_next.digit_gap_time = cfg_wdata[octbl_pkg::TIME_W-1:0];
                octbl_pkg::CFG_REPEAT_GAP:
                    cfg_next.repeat_gap_time = cfg_wdata[octbl_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.on_color        <= octbl_pkg::RST_ON_COLOR;
            cfg_reg.pulse_on_time   <= octbl_pkg::RST_PULSE_ON;
            cfg_reg.pulse_off_time  <= octbl_pkg::RST_PULSE_OFF;
            cfg_reg.zero_on_time    <= octbl_pkg::RST_ZERO_ON;
            cfg_reg.digit_gap_time  <= octbl_pkg::RST_DIGIT_GAP;
            cfg_reg.repeat_gap_time <= octbl_pkg::RST_REPEAT_GAP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/octbl_seq_core.sv -----
// ----------------------------------------------------------------------------
// octbl_seq_core
// Blink sequencer state and its combinational update for one item.
// ----------------------------------------------------------------------------
module octbl_seq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  octbl_pkg::item_t     item,
    input  octbl_pkg::cfg_t      cfg,
    output octbl_pkg::result_t   res
);

    localparam int DW = octbl_pkg::DIGIT_W;
    localparam int TW = octbl_pkg::TIME_W;

    logic [DW-1:0]     digit_store_reg [0:2];
    logic [DW-1:0]     digit_store_next [0:2];
    logic [1:0]        digit_count_reg, digit_count_next;
    logic [1:0]        digit_index_reg, digit_index_next;
    logic [DW-1:0]     pulses_done_reg, pulses_done_next;
    logic [DW-1:0]     pulses_target_reg, pulses_target_next;
    octbl_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]     ticks_left_reg, ticks_left_next;

    octbl_pkg::split_t split;
    logic [TW-1:0]     ticks_dec;
    logic [DW-1:0]     done_inc;
    logic [1:0]        index_inc;
    logic [1:0]        index_sel;
    logic              start;
    logic [DW-1:0]     start_digit;
    logic              start_zero;

    assign split     = octbl_pkg::split_octet(item.octet_value);
    assign ticks_dec = (ticks_left_reg != '0) ? TW'(ticks_left_reg - 1'b1) : '0;
    assign done_inc  = DW'(pulses_done_reg + 1'b1);
    assign index_inc = 2'(digit_index_reg + 1'b1);
    // an index past the store reads the first digit
    assign index_sel = (index_inc < 2'd3) ? index_inc : 2'd0;

    // next state and result
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            digit_store_next[i] = digit_store_reg[i];
        digit_count_next   = digit_count_reg;
        digit_index_next   = digit_index_reg;
        pulses_done_next   = pulses_done_reg;
        pulses_target_next = pulses_target_reg;
        phase_next         = phase_reg;
        ticks_left_next    = ticks_left_reg;
        res.valid          = 1'b0;
        res.rgb            = cfg.on_color;
        start              = 1'b0;
        start_digit        = digit_store_reg[0];
        start_zero         = 1'b0;

        unique case (item.kind)
            octbl_pkg::KIND_TICK:
            begin
                ticks_left_next = ticks_dec;
                if (ticks_dec == '0) begin
                    unique case (phase_reg)
                        octbl_pkg::PHASE_ON:
                        begin
                            pulses_done_next = done_inc;
                            if (done_inc >= pulses_target_reg) begin
                                phase_next      = octbl_pkg::PHASE_DGAP;
                                ticks_left_next = cfg.digit_gap_time;
                            end else begin
                                phase_next      = octbl_pkg::PHASE_OFF;
                                ticks_left_next = cfg.pulse_off_time;
                            end
                            res.valid = 1'b1;
                            res.rgb   = '0;
                        end
                        octbl_pkg::PHASE_OFF:
                        begin
                            phase_next      = octbl_pkg::PHASE_ON;
                            ticks_left_next = cfg.pulse_on_time;
                            res.valid       = 1'b1;
                        end
                        octbl_pkg::PHASE_DGAP:
                        begin
                            digit_index_next = index_inc;
                            if (index_inc >= digit_count_reg) begin
                                phase_next      = octbl_pkg::PHASE_RGAP;
                                ticks_left_next = cfg.repeat_gap_time;
                            end else begin
                                start       = 1'b1;
                                start_digit = digit_store_reg[index_sel];
                            end
                        end
                        octbl_pkg::PHASE_RGAP:
                        begin
                            digit_index_next = 2'd0;
                            start            = 1'b1;
                            start_digit      = digit_store_reg[0];
                        end
                    endcase
                end
            end
            octbl_pkg::KIND_LOAD:
            begin
                digit_store_next[0] = split.d0;
                if (split.count >= 2'd2)
                    digit_store_next[1] = split.d1;
                if (split.count == 2'd3)
                    digit_store_next[2] = split.d2;
                digit_count_next = split.count;
                digit_index_next = 2'd0;
                start            = 1'b1;
                start_digit      = split.d0;
            end
            octbl_pkg::KIND_SOLID:
            begin
                res.valid = 1'b1;
                res.rgb   = item.solid_color;
            end
            default: ;
        endcase

        // light the first pulse of a new digit
        if (start) begin
            start_zero         = (start_digit == '0);
            pulses_target_next = start_zero ? DW'(1) : start_digit;
            pulses_done_next   = '0;
            phase_next         = octbl_pkg::PHASE_ON;
            ticks_left_next    = start_zero ? cfg.zero_on_time : cfg.pulse_on_time;
            res.valid          = 1'b1;
            res.rgb            = cfg.on_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++)
                digit_store_reg[i] <= '0;
            digit_count_reg   <= 2'd1;
            digit_index_reg   <= 2'd0;
            pulses_done_reg   <= '0;
            pulses_target_reg <= '0;
            phase_reg         <= octbl_pkg::PHASE_ON;
            ticks_left_reg    <= '0;
        end else if (step) begin
            for (int i = 0; i < 3; i++)
                digit_store_reg[i] <= digit_store_next[i];
            digit_count_reg   <= digit_count_next;
            digit_index_reg   <= digit_index_next;
            pulses_done_reg   <= pulses_done_next;
            pulses_target_reg <= pulses_target_next;
            phase_reg         <= phase_next;
            ticks_left_reg    <= ticks_left_next;
        end
    end

endmodule

// ----- sv/octet_blink_code_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// octet_blink_code_sequencer_core
// Shows a byte as decimal blink codes on one RGB LED; emits each new colour.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | in        | in_valid / in_stall | kind, octet_value, solid_color
//  out     | out       | out_valid/out_stall | led_rgb
//  cfg     | in        | cfg_we              | cfg_index, cfg_wdata
//
//  One item per cycle while the output is not stalled: an accepted item
//  waits in the input register while the sequencer update runs on it, and
//  its colour, if it gives one, is loaded into the output register once
//  that register can be refilled and is offered there until it is taken.
//  Reset restores the default colour and times and a single zero digit.
//  A stalled full output register holds the whole pipe.
// ----------------------------------------------------------------------------
module octet_blink_code_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [octbl_pkg::KIND_W-1:0]        kind,
    input  logic [octbl_pkg::OCTET_W-1:0]       octet_value,
    input  logic [octbl_pkg::RGB_W-1:0]         solid_color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [octbl_pkg::RGB_W-1:0]         led_rgb,
    input  logic                                cfg_we,
    input  logic [octbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [octbl_pkg::RGB_W-1:0]         cfg_wdata
);

    octbl_pkg::cfg_t    cfg;
    octbl_pkg::item_t   item_reg;
    octbl_pkg::result_t res;
    logic               item_valid_reg;
    logic               out_valid_reg;
    logic [octbl_pkg::RGB_W-1:0] rgb_reg;
    logic               advance;
    logic               step;
    logic               in_take;

    // the pipe moves whenever the output register can be refilled
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    octbl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    octbl_seq_core u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_take)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            item_reg.kind        <= kind;
            item_reg.octet_value <= octet_value;
            item_reg.solid_color <= solid_color;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
            rgb_reg <= res.rgb;
    end

    assign out_valid = out_valid_reg;
    assign led_rgb   = rgb_reg;

    // a load lights the LED with the on colour
    a_load_lights: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.kind == octbl_pkg::KIND_LOAD
        |=> out_valid_reg && led_rgb == $past(cfg.on_color))
        else $error("load did not light the LED with the on colour");

    // a solid colour item goes straight out
    a_solid_passes: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.kind == octbl_pkg::KIND_SOLID
        |=> out_valid_reg && led_rgb == $past(item_reg.solid_color))
        else $error("solid colour not delivered");

    // an undefined kind gives no result
    a_undef_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.kind != octbl_pkg::KIND_TICK
        && item_reg.kind != octbl_pkg::KIND_LOAD
        && item_reg.kind != octbl_pkg::KIND_SOLID
        |=> !out_valid_reg)
        else $error("undefined kind produced a result");

endmodule
